@@ rtl/core/rpo_pkg.sv @@
package rpo_pkg;

	// Sine and cosine in Q15, with headroom for the CORDIC growth.
	localparam int CS_W = 18;
	// CORDIC angle accumulator, 2^20 units per turn.
	localparam int ANG_W = 22;
	// Corner coordinates in Q9, relative to the first centre.
	localparam int CRD_W = 36;
	// Centre offset of the second rectangle in Q9.
	localparam int CTR_W = 34;

	localparam int CORDIC_STEPS = 16;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

	localparam int QUARTER_TURN = 16384;
	localparam int HALF_TURN = 32768;

	localparam logic [2:0] SEP_NONE    = 3'd0;
	localparam logic [2:0] SEP_QUICK   = 3'd1;
	localparam logic [2:0] SEP_A_RIGHT = 3'd2;
	localparam logic [2:0] SEP_A_UP    = 3'd3;
	localparam logic [2:0] SEP_B_RIGHT = 3'd4;
	localparam logic [2:0] SEP_B_UP    = 3'd5;

	typedef logic signed [CS_W-1:0]  cs_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic [15:0]        first_length;
		logic [15:0]        first_width;
		logic [15:0]        first_front_offset;
		logic signed [15:0] first_heading;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic [15:0]        second_length;
		logic [15:0]        second_width;
		logic [15:0]        second_front_offset;
		logic signed [15:0] second_heading;
	} item_t;

	typedef struct packed {
		logic       overlap;
		logic [2:0] separated_by;
	} result_t;

	// Corners in the order upper-left, upper-right, lower-right, lower-left.
	typedef struct packed {
		crd_t ulx;
		crd_t uly;
		crd_t urx;
		crd_t ury;
		crd_t lrx;
		crd_t lry;
		crd_t llx;
		crd_t lly;
	} rect_t;

	localparam cs_t CORDIC_GAIN = 18'sd19898;

	function automatic ang_t atan_at(input logic [3:0] idx);
		ang_t r;
		case (idx)
			4'd0:    r = 22'sd131072;
			4'd1:    r = 22'sd77376;
			4'd2:    r = 22'sd40884;
			4'd3:    r = 22'sd20753;
			4'd4:    r = 22'sd10417;
			4'd5:    r = 22'sd5213;
			4'd6:    r = 22'sd2607;
			4'd7:    r = 22'sd1304;
			4'd8:    r = 22'sd652;
			4'd9:    r = 22'sd326;
			4'd10:   r = 22'sd163;
			4'd11:   r = 22'sd81;
			4'd12:   r = 22'sd41;
			4'd13:   r = 22'sd20;
			4'd14:   r = 22'sd10;
			4'd15:   r = 22'sd5;
			default: r = 22'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/rpo_cordic.sv @@
module rpo_cordic (
	input  logic          clk,
	input  logic          en,
	input  rpo_pkg::ang_t z0,
	input  logic          neg0,
	output rpo_pkg::cs_t  cosv,
	output rpo_pkg::cs_t  sinv
);
	import rpo_pkg::*;

	cs_t  x_s   [CORDIC_STAGES];
	cs_t  y_s   [CORDIC_STAGES];
	ang_t z_s   [CORDIC_STAGES];
	logic neg_s [CORDIC_STAGES];

	cs_t  xi [CORDIC_STAGES];
	cs_t  yi [CORDIC_STAGES];
	ang_t zi [CORDIC_STAGES];
	logic ni [CORDIC_STAGES];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		cs_t  xo;
		cs_t  yo;
		ang_t zo;

		if (g == 0) begin : g_first
			assign xi[g] = CORDIC_GAIN;
			assign yi[g] = '0;
			assign zi[g] = z0;
			assign ni[g] = neg0;
		end else begin : g_next
			assign xi[g] = x_s[g-1];
			assign yi[g] = y_s[g-1];
			assign zi[g] = z_s[g-1];
			assign ni[g] = neg_s[g-1];
		end

		// Four micro-rotations per register stage.
		always_comb begin
			cs_t        xv;
			cs_t        yv;
			cs_t        xn;
			ang_t       zv;
			logic [3:0] idx;
			xv = xi[g];
			yv = yi[g];
			zv = zi[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				idx = 4'(g * STEPS_PER_STAGE + k);
				if (zv >= 0) begin
					xn = xv - (yv >>> idx);
					yv = yv + (xv >>> idx);
					zv = zv - atan_at(idx);
				end else begin
					xn = xv + (yv >>> idx);
					yv = yv - (xv >>> idx);
					zv = zv + atan_at(idx);
				end
				xv = xn;
			end
			xo = xv;
			yo = yv;
			zo = zv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g]   <= xo;
				y_s[g]   <= yo;
				z_s[g]   <= zo;
				neg_s[g] <= ni[g];
			end
		end
	end

	assign cosv = neg_s[CORDIC_STAGES-1] ? -x_s[CORDIC_STAGES-1] : x_s[CORDIC_STAGES-1];
	assign sinv = neg_s[CORDIC_STAGES-1] ? -y_s[CORDIC_STAGES-1] : y_s[CORDIC_STAGES-1];

endmodule

@@ rtl/core/rpo_corners.sv @@
module rpo_corners (
	input  logic                        clk,
	input  logic                        en,
	input  rpo_pkg::cs_t                cosv,
	input  rpo_pkg::cs_t                sinv,
	input  logic [15:0]                 len,
	input  logic [15:0]                 wid,
	input  logic [15:0]                 off,
	input  logic signed [rpo_pkg::CTR_W-1:0] cx,
	input  logic signed [rpo_pkg::CTR_W-1:0] cy,
	output rpo_pkg::rect_t              rect
);
	import rpo_pkg::*;

	typedef logic signed [2*CS_W-1:0] prod_t;

	logic signed [CS_W-1:0] lx_rear;
	logic signed [CS_W-1:0] lx_front;
	logic signed [CS_W-1:0] ly;

	prod_t rc_s6, rs_s6, fc_s6, fs_s6, wc_s6, ws_s6;
	logic signed [CTR_W-1:0] cx_s6, cy_s6;

	assign lx_front = $signed({1'b0, off, 1'b0});
	assign lx_rear  = $signed({1'b0, off, 1'b0}) - $signed({1'b0, len, 1'b0});
	assign ly       = $signed({2'b00, wid});

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s6 <= prod_t'(lx_rear) * prod_t'(cosv);
			rs_s6 <= prod_t'(lx_rear) * prod_t'(sinv);
			fc_s6 <= prod_t'(lx_front) * prod_t'(cosv);
			fs_s6 <= prod_t'(lx_front) * prod_t'(sinv);
			wc_s6 <= prod_t'(ly) * prod_t'(cosv);
			ws_s6 <= prod_t'(ly) * prod_t'(sinv);
			cx_s6 <= cx;
			cy_s6 <= cy;
		end
	end

	// Round half up from Q24 to Q9, then move to the centre.
	function automatic crd_t place(input logic signed [CTR_W-1:0] c,
			input logic signed [2*CS_W:0] v);
		logic signed [2*CS_W+1:0] t;
		t = 38'(v) + 38'sd16384;
		return CRD_W'(c) + CRD_W'(t >>> 15);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			rect.ulx <= place(cx_s6, 37'(rc_s6) - 37'(ws_s6));
			rect.uly <= place(cy_s6, 37'(rs_s6) + 37'(wc_s6));
			rect.urx <= place(cx_s6, 37'(fc_s6) - 37'(ws_s6));
			rect.ury <= place(cy_s6, 37'(fs_s6) + 37'(wc_s6));
			rect.lrx <= place(cx_s6, 37'(fc_s6) + 37'(ws_s6));
			rect.lry <= place(cy_s6, 37'(fs_s6) - 37'(wc_s6));
			rect.llx <= place(cx_s6, 37'(rc_s6) + 37'(ws_s6));
			rect.lly <= place(cy_s6, 37'(rs_s6) - 37'(wc_s6));
		end
	end

endmodule

@@ rtl/core/rpo_sat.sv @@
module rpo_sat (
	input  logic           clk,
	input  logic           en,
	input  rpo_pkg::rect_t a,
	input  rpo_pkg::rect_t b,
	input  logic [18:0]    qlim,
	output logic           quick,
	output logic [3:0]     sep
);
	import rpo_pkg::*;

	// When the quick test passes, every corner lies within 2^21 of the
	// first upper-left corner, so narrow relative coordinates suffice.
	localparam int REL_W = 24;
	localparam int NRM_W = 21;
	localparam int DOT_W = REL_W + NRM_W + 1;

	typedef logic signed [REL_W-1:0] rel_t;
	typedef logic signed [NRM_W-1:0] nrm_t;
	typedef logic signed [DOT_W-1:0] dot_t;

	rel_t ax_s8 [4], ay_s8 [4], bx_s8 [4], by_s8 [4];
	nrm_t nx_s8 [4], ny_s8 [4];
	logic quick_s8, quick_s9;

	rel_t ax [4], ay [4], bx [4], by [4];
	logic signed [CRD_W:0] ex, ey;
	logic [CRD_W:0] ex_abs, ey_abs;

	function automatic rel_t rel(input crd_t v, input crd_t r);
		logic signed [CRD_W:0] d;
		d = (CRD_W+1)'(v) - (CRD_W+1)'(r);
		return d[REL_W-1:0];
	endfunction

	always_comb begin
		ax[0] = rel(a.ulx, a.ulx); ay[0] = rel(a.uly, a.uly);
		ax[1] = rel(a.urx, a.ulx); ay[1] = rel(a.ury, a.uly);
		ax[2] = rel(a.lrx, a.ulx); ay[2] = rel(a.lry, a.uly);
		ax[3] = rel(a.llx, a.ulx); ay[3] = rel(a.lly, a.uly);
		bx[0] = rel(b.ulx, a.ulx); by[0] = rel(b.uly, a.uly);
		bx[1] = rel(b.urx, a.ulx); by[1] = rel(b.ury, a.uly);
		bx[2] = rel(b.lrx, a.ulx); by[2] = rel(b.lry, a.uly);
		bx[3] = rel(b.llx, a.ulx); by[3] = rel(b.lly, a.uly);
		ex = (CRD_W+1)'(a.ulx) - (CRD_W+1)'(b.ulx);
		ey = (CRD_W+1)'(a.uly) - (CRD_W+1)'(b.uly);
		ex_abs = ex[CRD_W] ? (CRD_W+1)'(-ex) : (CRD_W+1)'(ex);
		ey_abs = ey[CRD_W] ? (CRD_W+1)'(-ey) : (CRD_W+1)'(ey);
	end

	// Axis 0/1: first right and up normals, axis 2/3: the second's.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s8 <= ax;
			ay_s8 <= ay;
			bx_s8 <= bx;
			by_s8 <= by;
			nx_s8[0] <= NRM_W'(ax[2] - ax[3]); ny_s8[0] <= NRM_W'(ay[2] - ay[3]);
			nx_s8[1] <= NRM_W'(ax[0] - ax[3]); ny_s8[1] <= NRM_W'(ay[0] - ay[3]);
			nx_s8[2] <= NRM_W'(bx[2] - bx[3]); ny_s8[2] <= NRM_W'(by[2] - by[3]);
			nx_s8[3] <= NRM_W'(bx[0] - bx[3]); ny_s8[3] <= NRM_W'(by[0] - by[3]);
			quick_s8 <= (ex_abs > (CRD_W+1)'(qlim)) || (ey_abs > (CRD_W+1)'(qlim));
		end
	end

	// Per axis: two projections of the own corners, other rectangle's corners 0 to 3.
	dot_t own_s9 [4][2];
	dot_t oth_s9 [4][4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				for (int k = 0; k < 4; k++) begin
					if (n < 2)
						oth_s9[n][k] <= DOT_W'(bx_s8[k]) * DOT_W'(nx_s8[n])
							+ DOT_W'(by_s8[k]) * DOT_W'(ny_s8[n]);
					else
						oth_s9[n][k] <= DOT_W'(ax_s8[k]) * DOT_W'(nx_s8[n])
							+ DOT_W'(ay_s8[k]) * DOT_W'(ny_s8[n]);
				end
			end
			own_s9[0][0] <= DOT_W'(ax_s8[3]) * DOT_W'(nx_s8[0]) + DOT_W'(ay_s8[3]) * DOT_W'(ny_s8[0]);
			own_s9[0][1] <= DOT_W'(ax_s8[2]) * DOT_W'(nx_s8[0]) + DOT_W'(ay_s8[2]) * DOT_W'(ny_s8[0]);
			own_s9[1][0] <= DOT_W'(ax_s8[3]) * DOT_W'(nx_s8[1]) + DOT_W'(ay_s8[3]) * DOT_W'(ny_s8[1]);
			own_s9[1][1] <= DOT_W'(ax_s8[0]) * DOT_W'(nx_s8[1]) + DOT_W'(ay_s8[0]) * DOT_W'(ny_s8[1]);
			own_s9[2][0] <= DOT_W'(bx_s8[3]) * DOT_W'(nx_s8[2]) + DOT_W'(by_s8[3]) * DOT_W'(ny_s8[2]);
			own_s9[2][1] <= DOT_W'(bx_s8[2]) * DOT_W'(nx_s8[2]) + DOT_W'(by_s8[2]) * DOT_W'(ny_s8[2]);
			own_s9[3][0] <= DOT_W'(bx_s8[3]) * DOT_W'(nx_s8[3]) + DOT_W'(by_s8[3]) * DOT_W'(ny_s8[3]);
			own_s9[3][1] <= DOT_W'(bx_s8[0]) * DOT_W'(nx_s8[3]) + DOT_W'(by_s8[0]) * DOT_W'(ny_s8[3]);
			quick_s9 <= quick_s8;
		end
	end

	logic [3:0] sep_c;

	always_comb begin
		dot_t amax, amin, bmax, bmin;
		for (int n = 0; n < 4; n++) begin
			amax = (own_s9[n][0] > own_s9[n][1]) ? own_s9[n][0] : own_s9[n][1];
			amin = (own_s9[n][0] < own_s9[n][1]) ? own_s9[n][0] : own_s9[n][1];
			bmax = oth_s9[n][0];
			bmin = oth_s9[n][0];
			for (int k = 1; k < 4; k++) begin
				if (oth_s9[n][k] > bmax)
					bmax = oth_s9[n][k];
				if (oth_s9[n][k] < bmin)
					bmin = oth_s9[n][k];
			end
			sep_c[n] = (amax < bmin) || (bmax < amin);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sep   <= sep_c;
			quick <= quick_s9;
		end
	end

endmodule

@@ rtl/core/rect_pair_overlap_sat.sv @@
// Collision test for a pair of oriented rectangles, one pair per transfer.
// The input channel (item_valid, item_stall, item) carries both rectangles;
// the output channel (result_valid, result_stall, result) returns one
// overlap flag and the code of the test that separated the pair.
// tol_we writes tol_wdata into the heading tolerance; write it only while
// no transfer is in flight.
// A new pair is taken in every cycle while the output is not stalled. The
// pipeline has an input stage, four CORDIC stages of four rotations each,
// two corner stages, and the normal, projection, compare and output stages.
// When the receiver stalls a valid result, the whole pipeline holds and
// item_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets the heading tolerance to 1.
module rect_pair_overlap_sat (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tol_we,
	input  logic [9:0]       tol_wdata,
	input  logic             item_valid,
	output logic             item_stall,
	input  rpo_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output rpo_pkg::result_t result
);
	import rpo_pkg::*;

	localparam int VLD_N = 10;

	typedef struct packed {
		logic [15:0]             len1;
		logic [15:0]             wid1;
		logic [15:0]             off1;
		logic [15:0]             len2;
		logic [15:0]             wid2;
		logic [15:0]             off2;
		logic signed [CTR_W-1:0] dx;
		logic signed [CTR_W-1:0] dy;
		logic [18:0]             qlim;
		logic                    aligned;
	} side_t;

	logic       en;
	logic [9:0] tol_q;
	logic       vld_s [1:VLD_N];

	assign en         = !(result_valid && result_stall);
	assign item_stall = result_valid && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 10'd1;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= VLD_N; k++)
				vld_s[k] <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			vld_s[1] <= item_valid;
			for (int k = 2; k <= VLD_N; k++)
				vld_s[k] <= vld_s[k-1];
			result_valid <= vld_s[VLD_N];
		end
	end

	// Input stage: fold headings, centre offset, quick limit, alignment.
	function automatic ang_t fold_z(input logic signed [15:0] h);
		logic signed [16:0] hf;
		hf = 17'(h);
		if (hf > 17'sd16384)
			hf = hf - 17'sd32768;
		else if (hf < -17'sd16384)
			hf = hf + 17'sd32768;
		return ANG_W'(hf) <<< 4;
	endfunction

	function automatic logic fold_neg(input logic signed [15:0] h);
		return (17'(h) > 17'sd16384) || (17'(h) < -17'sd16384);
	endfunction

	function automatic logic [16:0] habs(input logic signed [15:0] h);
		logic signed [16:0] w;
		w = 17'(h);
		return w[16] ? 17'(-w) : 17'(w);
	endfunction

	logic [16:0] h1a, h2a, hd;
	side_t       side_c;

	always_comb begin
		h1a = habs(item.first_heading);
		h2a = habs(item.second_heading);
		hd  = (h1a > h2a) ? h1a - h2a : h2a - h1a;
		side_c.len1 = item.first_length;
		side_c.wid1 = item.first_width;
		side_c.off1 = item.first_front_offset;
		side_c.len2 = item.second_length;
		side_c.wid2 = item.second_width;
		side_c.off2 = item.second_front_offset;
		side_c.dx   = (CTR_W'(item.second_pos_x) - CTR_W'(item.first_pos_x)) <<< 1;
		side_c.dy   = (CTR_W'(item.second_pos_y) - CTR_W'(item.first_pos_y)) <<< 1;
		side_c.qlim = (19'(item.first_length) + 19'(item.first_width)
			+ 19'(item.second_length) + 19'(item.second_width)) << 1;
		side_c.aligned = hd <= 17'(tol_q);
	end

	ang_t  z1_s1, z2_s1;
	logic  neg1_s1, neg2_s1;
	side_t sd_s [1:5];
	logic  al_s [6:10];
	logic [18:0] q_s6, q_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			z1_s1   <= fold_z(item.first_heading);
			z2_s1   <= fold_z(item.second_heading);
			neg1_s1 <= fold_neg(item.first_heading);
			neg2_s1 <= fold_neg(item.second_heading);
			sd_s[1] <= side_c;
			for (int k = 2; k <= 5; k++)
				sd_s[k] <= sd_s[k-1];
			q_s6    <= sd_s[5].qlim;
			q_s7    <= q_s6;
			al_s[6] <= sd_s[5].aligned;
			for (int k = 7; k <= 10; k++)
				al_s[k] <= al_s[k-1];
		end
	end

	cs_t c1, s1, c2, s2;

	rpo_cordic u_cordic_a (
		.clk(clk), .en(en), .z0(z1_s1), .neg0(neg1_s1), .cosv(c1), .sinv(s1)
	);

	rpo_cordic u_cordic_b (
		.clk(clk), .en(en), .z0(z2_s1), .neg0(neg2_s1), .cosv(c2), .sinv(s2)
	);

	rect_t ra, rb;

	rpo_corners u_corners_a (
		.clk(clk), .en(en), .cosv(c1), .sinv(s1),
		.len(sd_s[5].len1), .wid(sd_s[5].wid1), .off(sd_s[5].off1),
		.cx('0), .cy('0), .rect(ra)
	);

	rpo_corners u_corners_b (
		.clk(clk), .en(en), .cosv(c2), .sinv(s2),
		.len(sd_s[5].len2), .wid(sd_s[5].wid2), .off(sd_s[5].off2),
		.cx(sd_s[5].dx), .cy(sd_s[5].dy), .rect(rb)
	);

	logic       quick;
	logic [3:0] sep;

	rpo_sat u_sat (
		.clk(clk), .en(en), .a(ra), .b(rb), .qlim(q_s7), .quick(quick), .sep(sep)
	);

	logic [2:0] code;

	always_comb begin
		if (quick)
			code = SEP_QUICK;
		else if (sep[0])
			code = SEP_A_RIGHT;
		else if (sep[1])
			code = SEP_A_UP;
		else if (!al_s[10] && sep[2])
			code = SEP_B_RIGHT;
		else if (!al_s[10] && sep[3])
			code = SEP_B_UP;
		else
			code = SEP_NONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.overlap      <= (code == SEP_NONE);
			result.separated_by <= code;
		end
	end

endmodule
